// File: rtl/mibd_pkg.sv
// Shared types, codes and opcode helpers for the MOV byte decoder.
// Used by mibd_front, mibd_queue, mibd_back and the top level; no dependencies.
package mibd_pkg;

   // Instruction form codes; FORM_UNKNOWN never leaves the decoder as a form value
   localparam logic [2:0] FORM_RM_REG  = 3'd0;
   localparam logic [2:0] FORM_IMM_RM  = 3'd1;
   localparam logic [2:0] FORM_IMM_REG = 3'd2;
   localparam logic [2:0] FORM_ACC_MEM = 3'd3;
   localparam logic [2:0] FORM_UNKNOWN = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [1:0] STATUS_BAD_REG = 2'd2;

   // Opcode match patterns
   localparam logic [7:0] OP_RM_REG  = 8'h88;
   localparam logic [7:0] OP_IMM_RM  = 8'hC6;
   localparam logic [7:0] OP_IMM_REG = 8'hB0;
   localparam logic [7:0] OP_ACC_MEM = 8'hA0;

   localparam logic [1:0] MOD_MEM0   = 2'd0;
   localparam logic [1:0] MOD_MEM8   = 2'd1;
   localparam logic [1:0] MOD_MEM16  = 2'd2;
   localparam logic [1:0] MOD_REG    = 2'd3;
   localparam logic [2:0] RM_DIRECT  = 3'd6;
   localparam logic [7:0] MODRM_DIRECT = 8'h06;

   localparam int RSP_DATA_W = 48;

   // One finished instruction as handed from the front end to the back end
   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [1:0]  status;
      logic [15:0] displacement;
      logic [15:0] immediate;
   } rec_type;

   // Result beat, last field in the lowest bits
   typedef struct packed {
      logic [15:0] immediate;
      logic [15:0] displacement;
      logic [2:0]  rm_field;
      logic [2:0]  reg_field;
      logic [1:0]  mode;
      logic        wide;
      logic        to_reg;
      logic [1:0]  status;
      logic [1:0]  form;
   } rsp_type;

   function automatic logic [2:0] form_of(input logic [7:0] op);
      logic [2:0] f;
      if ((op & 8'hFC) == OP_RM_REG) f = FORM_RM_REG;
      else if ((op & 8'hFE) == OP_IMM_RM) f = FORM_IMM_RM;
      else if ((op & 8'hF0) == OP_IMM_REG) f = FORM_IMM_REG;
      else if ((op & 8'hFC) == OP_ACC_MEM) f = FORM_ACC_MEM;
      else f = FORM_UNKNOWN;
      return f;
   endfunction

   function automatic logic wide_of(input logic [7:0] op);
      return (form_of(op) == FORM_IMM_REG) ? op[3] : op[0];
   endfunction

   // Displacement bytes that follow a mod/reg/rm byte
   function automatic logic [1:0] disp_len(input logic [7:0] modrm);
      logic [1:0] n;
      unique case (modrm[7:6])
         MOD_MEM0:  n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
         MOD_MEM8:  n = 2'd1;
         MOD_MEM16: n = 2'd2;
         default:   n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [15:0] sext8(input logic [7:0] b);
      return {{8{b[7]}}, b};
   endfunction

endpackage

// File: rtl/mov_instruction_byte_decoder_top.sv
// Output: the record enters the queue at the accepting edge of the byte that ends an
//   instruction, and rsp_tvalid rises once the output register loads it from the queue;
//   bytes that complete nothing give no beat.
// Throughput: one byte per cycle while the queue has room, set by the byte-wide front end
//   state machine; the two-entry queue lets either side stall without losing records.
// Reset: synchronous, active high; clears phase, gathered bytes, queue and
//   output valid; the first byte after reset is taken as an opcode.
// Top level of the MOV byte decoder; uses mibd_pkg, mibd_front, mibd_queue, mibd_back.
module mov_instruction_byte_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // instruction byte beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   // decoded instruction beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [mibd_pkg::RSP_DATA_W-1:0] rsp_tdata
                                    // [1:0] form, [3:2] status, [4] to_reg, [5] wide,
                                    // [7:6] mode, [10:8] reg_field, [13:11] rm_field,
                                    // [29:14] displacement, [45:30] immediate, [47:46] 0
);

   logic              push;
   logic              push_ready;
   mibd_pkg::rec_type push_rec;
   logic              pop;
   logic              pop_valid;
   mibd_pkg::rec_type pop_rec;
   mibd_pkg::rsp_type rsp;

   // Byte collector: one beat per cycle while the queue has room, pushes a record when an instruction ends
   mibd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_value (req_tdata),
      .byte_ready (req_tready),
      .push       (push),
      .push_rec   (push_rec),
      .push_ready (push_ready)
   );

   // Decouples the collector from result back-pressure
   mibd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec)
   );

   // Field formatting and output register
   mibd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (pop_valid),
      .rec       (pop_rec),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {(mibd_pkg::RSP_DATA_W - $bits(rsp))'(0), rsp};

endmodule

// File: rtl/mibd_front.sv
// Front end: consumes instruction bytes and gathers opcode, mod/reg/rm,
// displacement and immediate into one record per instruction. Uses mibd_pkg.
module mibd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        byte_value,
   output logic              byte_ready,
   output logic              push,
   output mibd_pkg::rec_type push_rec,
   input  logic              push_ready
);

   localparam logic [1:0] PH_OPCODE = 2'd0;
   localparam logic [1:0] PH_MODRM  = 2'd1;
   localparam logic [1:0] PH_DISP   = 2'd2;
   localparam logic [1:0] PH_IMM    = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [15:0] disp_ff, disp_in;
   logic [7:0]  imm_low_ff, imm_low_in;
   logic [1:0]  left_ff, left_in;
   logic        accept;
   logic        done;
   logic [1:0]  status;
   logic [15:0] imm;

   assign byte_ready = push_ready;
   assign accept     = byte_valid && push_ready;

   always_comb begin
      logic [2:0] op_form;
      logic [2:0] b_form;
      logic       after_disp;
      op_form    = mibd_pkg::form_of(opcode_ff);
      b_form     = mibd_pkg::form_of(byte_value);
      after_disp = 1'b0;
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      modrm_in   = modrm_ff;
      disp_in    = disp_ff;
      imm_low_in = imm_low_ff;
      left_in    = left_ff;
      done       = 1'b0;
      status     = mibd_pkg::STATUS_OK;
      imm        = '0;
      unique case (phase_ff)
         PH_OPCODE: begin
            opcode_in  = byte_value;
            modrm_in   = '0;
            disp_in    = '0;
            imm_low_in = '0;
            left_in    = '0;
            unique case (b_form)
               mibd_pkg::FORM_RM_REG, mibd_pkg::FORM_IMM_RM: begin
                  phase_in = PH_MODRM;
               end
               mibd_pkg::FORM_IMM_REG: begin
                  phase_in = PH_IMM;
                  left_in  = byte_value[3] ? 2'd2 : 2'd1;
               end
               mibd_pkg::FORM_ACC_MEM: begin
                  phase_in = PH_DISP;
                  modrm_in = mibd_pkg::MODRM_DIRECT;
                  left_in  = 2'd2;
               end
               default: begin
                  phase_in = PH_OPCODE;
                  done     = 1'b1;
                  status   = mibd_pkg::STATUS_UNKNOWN;
               end
            endcase
         end
         PH_MODRM: begin
            modrm_in = byte_value;
            if (op_form == mibd_pkg::FORM_IMM_RM && byte_value[5:3] != 3'd0) begin
               phase_in = PH_OPCODE;
               done     = 1'b1;
               status   = mibd_pkg::STATUS_BAD_REG;
            end else if (mibd_pkg::disp_len(byte_value) != 2'd0) begin
               phase_in = PH_DISP;
               left_in  = mibd_pkg::disp_len(byte_value);
            end else begin
               after_disp = 1'b1;
            end
         end
         PH_DISP: begin
            if (mibd_pkg::disp_len(modrm_ff) == 2'd1) begin
               disp_in    = mibd_pkg::sext8(byte_value);
               left_in    = '0;
               after_disp = 1'b1;
            end else if (left_ff == 2'd2) begin
               disp_in = {8'h00, byte_value};
               left_in = 2'd1;
            end else begin
               disp_in    = {byte_value, disp_ff[7:0]};
               left_in    = '0;
               after_disp = 1'b1;
            end
         end
         default: begin
            if (left_ff == 2'd2) begin
               imm_low_in = byte_value;
               left_in    = 2'd1;
            end else begin
               left_in  = '0;
               phase_in = PH_OPCODE;
               done     = 1'b1;
               imm      = mibd_pkg::wide_of(opcode_ff) ? {byte_value, imm_low_ff}
                                                       : mibd_pkg::sext8(byte_value);
            end
         end
      endcase
      // C6/C7 go on to the immediate; every other form is complete here
      if (after_disp) begin
         if (op_form == mibd_pkg::FORM_IMM_RM) begin
            phase_in = PH_IMM;
            left_in  = mibd_pkg::wide_of(opcode_ff) ? 2'd2 : 2'd1;
         end else begin
            phase_in = PH_OPCODE;
            done     = 1'b1;
         end
      end
   end

   assign push = accept && done;

   always_comb begin
      push_rec.opcode       = opcode_in;
      push_rec.modrm        = modrm_in;
      push_rec.status       = status;
      push_rec.displacement = disp_in;
      push_rec.immediate    = imm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPCODE;
         opcode_ff  <= '0;
         modrm_ff   <= '0;
         disp_ff    <= '0;
         imm_low_ff <= '0;
         left_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         modrm_ff   <= modrm_in;
         disp_ff    <= disp_in;
         imm_low_ff <= imm_low_in;
         left_ff    <= left_in;
      end
   end

   a_push_resyncs: assert property (@(posedge clock) disable iff (reset)
      push |=> phase_ff == PH_OPCODE)
      else $error("front end did not return to opcode phase after a record");

endmodule

// File: rtl/mibd_queue.sv
// Two-entry record queue between front and back end.
// Uses mibd_pkg::rec_type.
module mibd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mibd_pkg::rec_type push_rec,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output mibd_pkg::rec_type pop_rec
);

   mibd_pkg::rec_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_rec    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

endmodule

// File: rtl/mibd_back.sv
// Back end: turns a queued record into the result fields and holds them
// in the output register until taken. Uses mibd_pkg.
module mibd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  mibd_pkg::rec_type rec,
   output logic              pop,
   output logic              rsp_valid,
   output mibd_pkg::rsp_type rsp,
   input  logic              rsp_ready
);

   logic              valid_ff, valid_in;
   mibd_pkg::rsp_type rsp_ff, rsp_in;

   assign pop       = rec_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      logic [2:0] f;
      f      = mibd_pkg::form_of(rec.opcode);
      rsp_in = '0;
      rsp_in.status = rec.status;
      if (rec.status != mibd_pkg::STATUS_UNKNOWN) begin
         rsp_in.form         = f[1:0];
         rsp_in.wide         = mibd_pkg::wide_of(rec.opcode);
         rsp_in.displacement = rec.displacement;
         rsp_in.immediate    = rec.immediate;
         unique case (f)
            mibd_pkg::FORM_RM_REG, mibd_pkg::FORM_IMM_RM: begin
               rsp_in.to_reg    = (f == mibd_pkg::FORM_RM_REG) ? rec.opcode[1] : 1'b0;
               rsp_in.mode      = rec.modrm[7:6];
               rsp_in.reg_field = rec.modrm[5:3];
               rsp_in.rm_field  = rec.modrm[2:0];
            end
            mibd_pkg::FORM_IMM_REG: begin
               rsp_in.to_reg    = 1'b1;
               rsp_in.mode      = mibd_pkg::MOD_REG;
               rsp_in.reg_field = rec.opcode[2:0];
            end
            mibd_pkg::FORM_ACC_MEM: begin
               rsp_in.to_reg   = ~rec.opcode[1];
               rsp_in.rm_field = mibd_pkg::RM_DIRECT;
            end
            default: begin
               rsp_in.form = '0;
            end
         endcase
      end
      valid_in = pop || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped record not presented");

   a_unknown_clear: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ff.status == mibd_pkg::STATUS_UNKNOWN) |->
         (rsp_ff.form == 2'd0 && rsp_ff.displacement == 16'd0 && rsp_ff.immediate == 16'd0))
      else $error("unknown-opcode beat carries field data");

endmodule
